// ----- rtl/core/mig_pkg.sv -----
// Shared types, constants and fixed-point helpers for the Gauss-Jordan
// matrix inverter. No dependencies.
package mig_pkg;

   localparam int MAX_ORDER = 8;
   localparam int ROW_BITS = 3;
   localparam int COL_BITS = 4;
   localparam int ADDR_BITS = ROW_BITS + COL_BITS;
   localparam int STORE_DEPTH = 1 << ADDR_BITS;
   localparam int DATA_W = 32;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_STEPS = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_THRESHOLD = 8'd1;

   localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_IDENT,
      ST_SRCH_START,
      ST_SRCH_BASE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SRCH_CHK,
      ST_SWP_RD0,
      ST_SWP_RD1,
      ST_SWP_W0,
      ST_SWP_W1,
      ST_EL_PIV,
      ST_EL_PIVL,
      ST_EL_ROW,
      ST_EL_DIV,
      ST_EL_DWAIT,
      ST_EL_RDP,
      ST_EL_RDR,
      ST_EL_MUL,
      ST_EL_SCL,
      ST_EL_WR,
      ST_FN_PIV,
      ST_FN_PIVL,
      ST_FN_RD,
      ST_FN_DIV,
      ST_FN_DWAIT,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT,
      ST_SING
   } state_type;

   typedef struct packed {
      logic                     start;
      logic signed [DATA_W-1:0] num;
      logic signed [DATA_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quo;
   } div_rsp_type;

   function automatic logic [DATA_W:0] mag33(input logic [DATA_W-1:0] v);
      logic [DATA_W:0] e;
      e = {v[DATA_W-1], v};
      return v[DATA_W-1] ? (~e + 33'd1) : e;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b);
      logic signed [DATA_W:0] d;
      d = {a[DATA_W-1], a} - {b[DATA_W-1], b};
      if (d[DATA_W] != d[DATA_W-1]) begin
         return d[DATA_W] ? Q_MIN : Q_MAX;
      end
      return d[DATA_W-1:0];
   endfunction

   // Drop 16 fraction bits toward zero, then clamp to 32 bits.
   function automatic logic signed [DATA_W-1:0] scale_prod(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = p[63] ? (p + 64'sd65535) : p;
      t = t >>> 16;
      if ((&t[63:31]) || (~|t[63:31])) begin
         return t[31:0];
      end
      return t[63] ? Q_MIN : Q_MAX;
   endfunction

endpackage

// ----- rtl/core/mig_ifc.sv -----
// Valid/ready channel interfaces for the matrix inverter.
// Depends on mig_pkg for widths.
interface mig_req_if ();
   logic                                    valid;
   logic                                    ready;
   logic signed [mig_pkg::DATA_W-1:0]       element;
   modport source (output valid, output element, input ready);
   modport sink (input valid, input element, output ready);
endinterface

interface mig_rsp_if ();
   logic                                    valid;
   logic                                    ready;
   logic signed [mig_pkg::DATA_W-1:0]       value;
   logic                                    singular;
   logic                                    last;
   modport source (output valid, output value, output singular, output last, input ready);
   modport sink (input valid, input value, input singular, input last, output ready);
endinterface

interface mig_csr_if ();
   logic                                    valid;
   logic                                    ready;
   logic [mig_pkg::CSR_IDX_W-1:0]           index;
   logic [mig_pkg::CSR_DATA_W-1:0]          data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/matrix_inverse_gauss_jordan.sv -----
// Top level: Gauss-Jordan matrix inverter with partial pivoting, Q16.16.
// Depends on mig_pkg, the mig_*_if interfaces, mig_ram and mig_div.
//
//   channel  dir  payload                   beat
//   req_if   in   element                   one matrix element, row-major
//   rsp_if   out  value, singular, last     one inverse element, row-major
//   csr_if   in   index, data               one register write
//
// Elements are taken only while loading; the last element of a matrix
// starts the solve and req_if stays low until the final result beat is
// taken. The solve is bounded by one RAM read port and the bit-serial
// divider (n*(n-1) + n*n divisions at order n); a multiply-subtract reads,
// multiplies, scales and writes back, and each output beat is held until
// taken. Reset is synchronous; the element store needs no clearing pass.
module matrix_inverse_gauss_jordan (
   input logic        clock,
   input logic        reset,
   mig_req_if.sink    req_if,
   mig_rsp_if.source  rsp_if,
   mig_csr_if.sink    csr_if
);

   localparam int AW = mig_pkg::ADDR_BITS;

   mig_pkg::state_type state_ff, state_in;

   logic [3:0]  size_ff, size_in;
   logic [15:0] thr_ff, thr_in;
   logic [6:0]  ld_cnt_ff, ld_cnt_in;
   logic [2:0]  ld_row_ff, ld_row_in;
   logic [2:0]  ld_col_ff, ld_col_in;
   logic [2:0]  k_ff, k_in;
   logic [3:0]  row_ff, row_in;
   logic [3:0]  col_ff, col_in;
   logic [2:0]  best_ff, best_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [32:0]        bestmag_ff, bestmag_in;
   logic signed [31:0] piv_ff, piv_in;
   logic signed [31:0] tmp_ff, tmp_in;
   logic signed [31:0] ratio_ff, ratio_in;
   logic signed [31:0] pk_ff, pk_in;
   logic signed [31:0] ar_ff, ar_in;
   logic signed [31:0] q_ff, q_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_sing_ff, rsp_sing_in;
   logic               rsp_last_ff, rsp_last_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [31:0]   ram_wdata, ram_rdata;

   mig_pkg::div_req_type div_req;
   mig_pkg::div_rsp_type div_rsp;

   logic [3:0] order;
   logic [6:0] order_sq;
   logic [4:0] order2;
   logic       req_acc, rsp_acc, csr_acc;
   logic       ld_last, col_last, k_last, row_last, sing_hit;
   logic [32:0] cur_mag;

   always_comb begin
      if (size_ff == 4'd0) begin
         order = 4'd1;
      end else if (size_ff > 4'(mig_pkg::MAX_ORDER)) begin
         order = 4'(mig_pkg::MAX_ORDER);
      end else begin
         order = size_ff;
      end
   end

   assign order_sq = 7'(order) * 7'(order);
   assign order2   = {order, 1'b0};
   assign req_acc  = req_if.valid && req_if.ready;
   assign rsp_acc  = rsp_if.valid && rsp_if.ready;
   assign csr_acc  = csr_if.valid && csr_if.ready;
   assign ld_last  = (ld_cnt_ff + 7'd1) == order_sq;
   assign col_last = ({1'b0, col_ff} + 5'd1) == order2;
   assign k_last   = ({1'b0, k_ff} + 4'd1) == order;
   assign row_last = (row_ff + 4'd1) == order;
   assign sing_hit = bestmag_ff <= {17'b0, thr_ff};
   assign cur_mag  = mig_pkg::mag33(ram_rdata);

   assign req_if.ready    = (state_ff == mig_pkg::ST_LOAD);
   assign csr_if.ready    = 1'b1;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.value    = rsp_value_ff;
   assign rsp_if.singular = rsp_sing_ff;
   assign rsp_if.last     = rsp_last_ff;

   mig_ram #(
      .WIDTH (mig_pkg::DATA_W),
      .DEPTH (mig_pkg::STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   mig_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mig_pkg::ST_LOAD: begin
            if (req_acc && ld_last) state_in = mig_pkg::ST_IDENT;
         end
         mig_pkg::ST_IDENT: begin
            if (row_last && ((col_ff + 4'd1) == order)) state_in = mig_pkg::ST_SRCH_START;
         end
         mig_pkg::ST_SRCH_START: state_in = mig_pkg::ST_SRCH_BASE;
         mig_pkg::ST_SRCH_BASE:  state_in = mig_pkg::ST_SRCH_RD;
         mig_pkg::ST_SRCH_RD: begin
            state_in = (row_ff == order) ? mig_pkg::ST_SRCH_CHK : mig_pkg::ST_SRCH_CMP;
         end
         mig_pkg::ST_SRCH_CMP: state_in = mig_pkg::ST_SRCH_RD;
         mig_pkg::ST_SRCH_CHK: begin
            if (sing_hit) begin
               state_in = mig_pkg::ST_SING;
            end else if (best_ff != k_ff) begin
               state_in = mig_pkg::ST_SWP_RD0;
            end else begin
               state_in = mig_pkg::ST_EL_PIV;
            end
         end
         mig_pkg::ST_SWP_RD0: state_in = mig_pkg::ST_SWP_RD1;
         mig_pkg::ST_SWP_RD1: state_in = mig_pkg::ST_SWP_W0;
         mig_pkg::ST_SWP_W0:  state_in = mig_pkg::ST_SWP_W1;
         mig_pkg::ST_SWP_W1: begin
            state_in = col_last ? mig_pkg::ST_EL_PIV : mig_pkg::ST_SWP_RD0;
         end
         mig_pkg::ST_EL_PIV:  state_in = mig_pkg::ST_EL_PIVL;
         mig_pkg::ST_EL_PIVL: state_in = mig_pkg::ST_EL_ROW;
         mig_pkg::ST_EL_ROW: begin
            if (row_ff == order) begin
               state_in = k_last ? mig_pkg::ST_FN_PIV : mig_pkg::ST_SRCH_START;
            end else if (row_ff != {1'b0, k_ff}) begin
               state_in = mig_pkg::ST_EL_DIV;
            end
         end
         mig_pkg::ST_EL_DIV: state_in = mig_pkg::ST_EL_DWAIT;
         mig_pkg::ST_EL_DWAIT: begin
            if (div_rsp.done) state_in = mig_pkg::ST_EL_RDP;
         end
         mig_pkg::ST_EL_RDP: state_in = mig_pkg::ST_EL_RDR;
         mig_pkg::ST_EL_RDR: state_in = mig_pkg::ST_EL_MUL;
         mig_pkg::ST_EL_MUL: state_in = mig_pkg::ST_EL_SCL;
         mig_pkg::ST_EL_SCL: state_in = mig_pkg::ST_EL_WR;
         mig_pkg::ST_EL_WR: begin
            state_in = col_last ? mig_pkg::ST_EL_ROW : mig_pkg::ST_EL_RDP;
         end
         mig_pkg::ST_FN_PIV:  state_in = mig_pkg::ST_FN_PIVL;
         mig_pkg::ST_FN_PIVL: state_in = mig_pkg::ST_FN_RD;
         mig_pkg::ST_FN_RD:   state_in = mig_pkg::ST_FN_DIV;
         mig_pkg::ST_FN_DIV:  state_in = mig_pkg::ST_FN_DWAIT;
         mig_pkg::ST_FN_DWAIT: begin
            if (div_rsp.done) begin
               if (!col_last) begin
                  state_in = mig_pkg::ST_FN_RD;
               end else begin
                  state_in = row_last ? mig_pkg::ST_OUT_RD : mig_pkg::ST_FN_PIV;
               end
            end
         end
         mig_pkg::ST_OUT_RD: state_in = mig_pkg::ST_OUT_LD;
         mig_pkg::ST_OUT_LD: state_in = mig_pkg::ST_OUT_WAIT;
         mig_pkg::ST_OUT_WAIT: begin
            if (rsp_acc) state_in = rsp_last_ff ? mig_pkg::ST_LOAD : mig_pkg::ST_OUT_RD;
         end
         mig_pkg::ST_SING: state_in = mig_pkg::ST_OUT_WAIT;
         default: state_in = mig_pkg::ST_LOAD;
      endcase
   end

   // Datapath, counters and store access.
   always_comb begin
      size_in      = size_ff;
      thr_in       = thr_ff;
      ld_cnt_in    = ld_cnt_ff;
      ld_row_in    = ld_row_ff;
      ld_col_in    = ld_col_ff;
      k_in         = k_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      bestmag_in   = bestmag_ff;
      piv_in       = piv_ff;
      tmp_in       = tmp_ff;
      ratio_in     = ratio_ff;
      pk_in        = pk_ff;
      ar_in        = ar_ff;
      q_in         = q_ff;
      prod_in      = prod_ff;
      rsp_value_in = rsp_value_ff;
      rsp_sing_in  = rsp_sing_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = '0;
      ram_raddr    = '0;
      ram_wdata    = '0;
      div_req.start = 1'b0;
      div_req.num   = ram_rdata;
      div_req.den   = piv_ff;

      case (state_ff)
         mig_pkg::ST_LOAD: begin
            if (req_acc) begin
               ram_we    = 1'b1;
               ram_waddr = {ld_row_ff, 1'b0, ld_col_ff};
               ram_wdata = req_if.element;
               if (ld_last) begin
                  ld_cnt_in = '0;
                  ld_row_in = '0;
                  ld_col_in = '0;
                  row_in    = '0;
                  col_in    = '0;
                  k_in      = '0;
               end else begin
                  ld_cnt_in = ld_cnt_ff + 7'd1;
                  if (({1'b0, ld_col_ff} + 4'd1) == order) begin
                     ld_col_in = '0;
                     ld_row_in = ld_row_ff + 3'd1;
                  end else begin
                     ld_col_in = ld_col_ff + 3'd1;
                  end
               end
            end
         end
         mig_pkg::ST_IDENT: begin
            ram_we    = 1'b1;
            ram_waddr = {row_ff[2:0], order + col_ff};
            ram_wdata = (row_ff == col_ff) ? mig_pkg::Q_ONE : '0;
            if ((col_ff + 4'd1) == order) begin
               col_in = '0;
               row_in = row_ff + 4'd1;
            end else begin
               col_in = col_ff + 4'd1;
            end
         end
         mig_pkg::ST_SRCH_START: begin
            ram_re    = 1'b1;
            ram_raddr = {k_ff, 1'b0, k_ff};
            best_in   = k_ff;
            row_in    = {1'b0, k_ff} + 4'd1;
         end
         mig_pkg::ST_SRCH_BASE: begin
            bestmag_in = cur_mag;
         end
         mig_pkg::ST_SRCH_RD: begin
            if (row_ff != order) begin
               ram_re    = 1'b1;
               ram_raddr = {row_ff[2:0], 1'b0, k_ff};
            end
         end
         mig_pkg::ST_SRCH_CMP: begin
            // Strictly greater keeps the first row on ties.
            if (cur_mag > bestmag_ff) begin
               bestmag_in = cur_mag;
               best_in    = row_ff[2:0];
            end
            row_in = row_ff + 4'd1;
         end
         mig_pkg::ST_SRCH_CHK: begin
            col_in = {1'b0, k_ff};
         end
         mig_pkg::ST_SWP_RD0: begin
            ram_re    = 1'b1;
            ram_raddr = {k_ff, col_ff};
         end
         mig_pkg::ST_SWP_RD1: begin
            tmp_in    = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = {best_ff, col_ff};
         end
         mig_pkg::ST_SWP_W0: begin
            ram_we    = 1'b1;
            ram_waddr = {k_ff, col_ff};
            ram_wdata = ram_rdata;
         end
         mig_pkg::ST_SWP_W1: begin
            ram_we    = 1'b1;
            ram_waddr = {best_ff, col_ff};
            ram_wdata = tmp_ff;
            col_in    = col_ff + 4'd1;
         end
         mig_pkg::ST_EL_PIV: begin
            ram_re    = 1'b1;
            ram_raddr = {k_ff, 1'b0, k_ff};
            row_in    = '0;
         end
         mig_pkg::ST_EL_PIVL: begin
            piv_in = ram_rdata;
         end
         mig_pkg::ST_EL_ROW: begin
            if (row_ff == order) begin
               row_in = '0;
               k_in   = k_last ? k_ff : (k_ff + 3'd1);
            end else if (row_ff == {1'b0, k_ff}) begin
               row_in = row_ff + 4'd1;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = {row_ff[2:0], 1'b0, k_ff};
            end
         end
         mig_pkg::ST_EL_DIV: begin
            div_req.start = 1'b1;
         end
         mig_pkg::ST_EL_DWAIT: begin
            if (div_rsp.done) begin
               ratio_in  = div_rsp.quo;
               ram_we    = 1'b1;
               ram_waddr = {row_ff[2:0], 1'b0, k_ff};
               ram_wdata = '0;
               col_in    = {1'b0, k_ff} + 4'd1;
            end
         end
         mig_pkg::ST_EL_RDP: begin
            ram_re    = 1'b1;
            ram_raddr = {k_ff, col_ff};
         end
         mig_pkg::ST_EL_RDR: begin
            pk_in     = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = {row_ff[2:0], col_ff};
         end
         mig_pkg::ST_EL_MUL: begin
            ar_in   = ram_rdata;
            prod_in = ratio_ff * pk_ff;
         end
         mig_pkg::ST_EL_SCL: begin
            q_in = mig_pkg::scale_prod(prod_ff);
         end
         mig_pkg::ST_EL_WR: begin
            ram_we    = 1'b1;
            ram_waddr = {row_ff[2:0], col_ff};
            ram_wdata = mig_pkg::sat_sub(ar_ff, q_ff);
            if (col_last) begin
               row_in = row_ff + 4'd1;
            end else begin
               col_in = col_ff + 4'd1;
            end
         end
         mig_pkg::ST_FN_PIV: begin
            ram_re    = 1'b1;
            ram_raddr = {row_ff[2:0], 1'b0, row_ff[2:0]};
         end
         mig_pkg::ST_FN_PIVL: begin
            piv_in = ram_rdata;
            col_in = order;
         end
         mig_pkg::ST_FN_RD: begin
            ram_re    = 1'b1;
            ram_raddr = {row_ff[2:0], col_ff};
         end
         mig_pkg::ST_FN_DIV: begin
            div_req.start = 1'b1;
         end
         mig_pkg::ST_FN_DWAIT: begin
            if (div_rsp.done) begin
               ram_we    = 1'b1;
               ram_waddr = {row_ff[2:0], col_ff};
               ram_wdata = div_rsp.quo;
               if (!col_last) begin
                  col_in = col_ff + 4'd1;
               end else if (row_last) begin
                  row_in = '0;
                  col_in = '0;
               end else begin
                  row_in = row_ff + 4'd1;
               end
            end
         end
         mig_pkg::ST_OUT_RD: begin
            ram_re    = 1'b1;
            ram_raddr = {row_ff[2:0], order + col_ff};
         end
         mig_pkg::ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = ram_rdata;
            rsp_sing_in  = 1'b0;
            rsp_last_in  = row_last && ((col_ff + 4'd1) == order);
         end
         mig_pkg::ST_OUT_WAIT: begin
            if (rsp_acc) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  row_in  = '0;
                  col_in  = '0;
                  k_in    = '0;
                  best_in = '0;
               end else if ((col_ff + 4'd1) == order) begin
                  col_in = '0;
                  row_in = row_ff + 4'd1;
               end else begin
                  col_in = col_ff + 4'd1;
               end
            end
         end
         mig_pkg::ST_SING: begin
            rsp_valid_in = 1'b1;
            rsp_value_in = '0;
            rsp_sing_in  = 1'b1;
            rsp_last_in  = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      // A size write drops any partly loaded matrix.
      if (csr_acc) begin
         if (csr_if.index == mig_pkg::CSR_MATRIX_SIZE) begin
            size_in   = csr_if.data[3:0];
            ld_cnt_in = '0;
            ld_row_in = '0;
            ld_col_in = '0;
         end else if (csr_if.index == mig_pkg::CSR_PIVOT_THRESHOLD) begin
            thr_in = csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mig_pkg::ST_LOAD;
         size_ff      <= 4'(mig_pkg::MAX_ORDER);
         thr_ff       <= '0;
         ld_cnt_ff    <= '0;
         ld_row_ff    <= '0;
         ld_col_ff    <= '0;
         k_ff         <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         thr_ff       <= thr_in;
         ld_cnt_ff    <= ld_cnt_in;
         ld_row_ff    <= ld_row_in;
         ld_col_ff    <= ld_col_in;
         k_ff         <= k_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bestmag_ff   <= bestmag_in;
      piv_ff       <= piv_in;
      tmp_ff       <= tmp_in;
      ratio_ff     <= ratio_in;
      pk_ff        <= pk_in;
      ar_ff        <= ar_in;
      q_ff         <= q_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sing_ff  <= rsp_sing_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ----- rtl/core/mig_ram.sv -----
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module mig_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/mig_div.sv -----
// Radix-2 restoring divider for Q16.16 quotients, one bit per cycle.
// Depends on mig_pkg for the request and response structs.
module mig_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mig_pkg::div_req_type req,
   output mig_pkg::div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic [47:0] nsh_ff, nsh_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [47:0] quo_ff, quo_in;
   logic [32:0] rem_t;
   logic [31:0] num_abs;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      nsh_in  = nsh_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      num_abs = req.num[31] ? (~req.num + 32'd1) : req.num;
      rem_t   = {rem_ff, nsh_ff[47]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = req.num[31] ^ req.den[31];
         zero_in = (req.den == '0);
         nsh_in  = {num_abs, 16'b0};
         den_in  = req.den[31] ? (~req.den + 32'd1) : req.den;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         nsh_in = {nsh_ff[46:0], 1'b0};
         if (rem_t >= {1'b0, den_ff}) begin
            rem_in = 32'(rem_t - {1'b0, den_ff});
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = rem_t[31:0];
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(mig_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      nsh_ff  <= nsh_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   // Apply sign and clamp to the 32-bit range; a zero divisor gives zero.
   always_comb begin
      rsp.done = done_ff;
      if (zero_ff) begin
         rsp.quo = '0;
      end else if (neg_ff) begin
         rsp.quo = (quo_ff >= 48'h0000_8000_0000) ? mig_pkg::Q_MIN : -$signed(quo_ff[31:0]);
      end else begin
         rsp.quo = (quo_ff > 48'h0000_7fff_ffff) ? mig_pkg::Q_MAX : $signed(quo_ff[31:0]);
      end
   end

endmodule

// ----- test/tb_matrix_inverse_gauss_jordan.sv -----
// Self-checking testbench for matrix_inverse_gauss_jordan: loads matrices of
// several orders, predicts each inverse beat in fixed point and checks it.
// Depends on mig_pkg and the mig_*_if interfaces.
module tb_matrix_inverse_gauss_jordan;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 430;

   typedef struct {
      logic signed [mig_pkg::DATA_W-1:0] value;
      logic                              singular;
      logic                              last;
   } inverse_beat_type;

   logic clock = 1'b0;
   logic reset;

   mig_req_if req_bus ();
   mig_rsp_if rsp_bus ();
   mig_csr_if csr_bus ();

   matrix_inverse_gauss_jordan u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state
   logic signed [mig_pkg::DATA_W-1:0] aug_rows [mig_pkg::MAX_ORDER][2*mig_pkg::MAX_ORDER];
   int unsigned                       loaded_count;
   logic [3:0]                        size_reg;
   logic [15:0]                       threshold_reg;
   inverse_beat_type                  inverse_q [$];

   int unsigned error_count;
   int unsigned cycle_count = 0;
   int unsigned burst_left;
   int unsigned items_sent;
   int unsigned big_matrices;
   int          stall_mode = 0;

   function automatic logic signed [mig_pkg::DATA_W-1:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return mig_pkg::Q_MAX;
      if (v < -64'sd2147483648) return mig_pkg::Q_MIN;
      return v[31:0];
   endfunction

   function automatic longint magnitude(input logic signed [mig_pkg::DATA_W-1:0] v);
      longint w;
      w = v;
      return (w < 0) ? -w : w;
   endfunction

   function automatic logic signed [mig_pkg::DATA_W-1:0] fx_mul(
         input logic signed [mig_pkg::DATA_W-1:0] a,
         input logic signed [mig_pkg::DATA_W-1:0] b);
      return clamp32((longint'(a) * longint'(b)) / 65536);
   endfunction

   function automatic logic signed [mig_pkg::DATA_W-1:0] fx_div(
         input logic signed [mig_pkg::DATA_W-1:0] a,
         input logic signed [mig_pkg::DATA_W-1:0] b);
      if (b == 0) return '0;
      return clamp32((longint'(a) * 65536) / longint'(b));
   endfunction

   function automatic int unsigned active_order();
      if (size_reg == 0) return 1;
      if (size_reg > mig_pkg::MAX_ORDER) return mig_pkg::MAX_ORDER;
      return {28'd0, size_reg};
   endfunction

   // Store one element; on the final one, solve and queue the inverse beats.
   function automatic void predict_inverse(input logic signed [mig_pkg::DATA_W-1:0] elem);
      int unsigned n, k, best, i, j, col;
      logic signed [mig_pkg::DATA_W-1:0] ratio, tmp, piv;
      inverse_beat_type beat;
      n = active_order();
      aug_rows[loaded_count / n][loaded_count % n] = elem;
      loaded_count = (loaded_count + 1) & 7'h7f;
      if (loaded_count < n * n) return;
      loaded_count = 0;
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++)
            aug_rows[i][n+j] = (i == j) ? mig_pkg::Q_ONE : '0;
      for (k = 0; k < n; k++) begin
         best = k;
         for (i = k + 1; i < n; i++)
            if (magnitude(aug_rows[i][k]) > magnitude(aug_rows[best][k])) best = i;
         if (magnitude(aug_rows[best][k]) <= longint'(threshold_reg)) begin
            beat.value = '0;
            beat.singular = 1'b1;
            beat.last = 1'b1;
            inverse_q.push_back(beat);
            return;
         end
         if (best != k) begin
            for (col = k; col < 2 * n; col++) begin
               tmp = aug_rows[k][col];
               aug_rows[k][col] = aug_rows[best][col];
               aug_rows[best][col] = tmp;
            end
         end
         for (i = 0; i < n; i++) begin
            if (i == k) continue;
            ratio = fx_div(aug_rows[i][k], aug_rows[k][k]);
            aug_rows[i][k] = '0;
            for (col = k + 1; col < 2 * n; col++)
               aug_rows[i][col] = clamp32(longint'(aug_rows[i][col]) -
                                          longint'(fx_mul(ratio, aug_rows[k][col])));
         end
      end
      for (i = 0; i < n; i++) begin
         piv = aug_rows[i][i];
         for (col = n; col < 2 * n; col++) aug_rows[i][col] = fx_div(aug_rows[i][col], piv);
         aug_rows[i][i] = mig_pkg::Q_ONE;
      end
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++) begin
            beat.value = aug_rows[i][n+j];
            beat.singular = 1'b0;
            beat.last = (i == n - 1) && (j == n - 1);
            inverse_q.push_back(beat);
         end
   endfunction

   task automatic report_mismatch(input string what, input longint expected, input longint got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, expected, got,
               cycle_count);
      error_count++;
   endtask

   // Result checker
   always @(posedge clock) begin
      inverse_beat_type exp_beat;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (inverse_q.size() == 0) begin
            report_mismatch("unexpected beat, value", 0, rsp_bus.value);
         end else begin
            exp_beat = inverse_q.pop_front();
            if (rsp_bus.value !== exp_beat.value)
               report_mismatch("value", exp_beat.value, rsp_bus.value);
            if (rsp_bus.singular !== exp_beat.singular)
               report_mismatch("singular", exp_beat.singular, rsp_bus.singular);
            if (rsp_bus.last !== exp_beat.last)
               report_mismatch("last", exp_beat.last, rsp_bus.last);
         end
      end
   end

   // Receiver stall pattern and run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 97 == 0) stall_mode <= int'($urandom_range(0, 2));
      case (stall_mode)
         0: begin
            rsp_bus.ready <= 1'b1;
         end
         1: begin
            rsp_bus.ready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         end
      endcase
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_element(input logic signed [mig_pkg::DATA_W-1:0] elem);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_bus.valid <= 1'b1;
      req_bus.element <= elem;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      items_sent++;
      predict_inverse(elem);
   endtask

   // Drop valid, drain all expected beats, then give the block time to go idle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (inverse_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [mig_pkg::CSR_IDX_W-1:0] idx,
                            input logic [mig_pkg::CSR_DATA_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == mig_pkg::CSR_MATRIX_SIZE) begin
         size_reg = val[3:0];
         loaded_count = 0;
      end else if (idx == mig_pkg::CSR_PIVOT_THRESHOLD) begin
         threshold_reg = val;
      end
      @(posedge clock);
   endtask

   task automatic configure(input int unsigned size, input int unsigned thresh);
      wait_idle();
      write_csr(mig_pkg::CSR_MATRIX_SIZE, 16'(size));
      write_csr(mig_pkg::CSR_PIVOT_THRESHOLD, 16'(thresh));
   endtask

   task automatic test_order_one_extremes();
      configure(1, 0);
      send_element(32'sd0);              // zero pivot at threshold zero: singular
      send_element(32'sd1);
      send_element(-32'sd1);
      send_element(mig_pkg::Q_MAX);
      send_element(mig_pkg::Q_MIN);
      send_element(mig_pkg::Q_ONE);
   endtask

   task automatic test_size_clamping();
      configure(0, 0);                   // zero acts as order one
      send_element(32'sd2 * mig_pkg::Q_ONE);
      send_element(-32'sd3 * mig_pkg::Q_ONE);
   endtask

   task automatic test_threshold_edge();
      configure(1, 16'hffff);
      send_element(32'sd65535);          // exactly at threshold: singular
      send_element(-32'sd65536);
   endtask

   task automatic test_pivot_swap_and_singular();
      configure(2, 0);
      // zero top-left forces a row swap
      send_element(32'sd0);
      send_element(mig_pkg::Q_ONE);
      send_element(32'sd2 * mig_pkg::Q_ONE);
      send_element(mig_pkg::Q_ONE);
      // all zero matrix
      repeat (4) send_element(32'sd0);
   endtask

   task automatic test_partial_load_dropped();
      configure(3, 0);
      send_element(32'sd5 * mig_pkg::Q_ONE);
      send_element(32'sd7 * mig_pkg::Q_ONE);
      wait_idle();
      write_csr(mig_pkg::CSR_MATRIX_SIZE, 16'd2);
      send_element(32'sd4 * mig_pkg::Q_ONE);
      send_element(mig_pkg::Q_ONE);
      send_element(-32'sd2 * mig_pkg::Q_ONE);
      send_element(32'sd3 * mig_pkg::Q_ONE);
   endtask

   task automatic send_random_matrix(input int unsigned n);
      logic signed [mig_pkg::DATA_W-1:0] mat [mig_pkg::MAX_ORDER][mig_pkg::MAX_ORDER];
      int unsigned kind, i, j, mag_int;
      kind = $urandom_range(0, 99);
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++) begin
            if (kind < 60) begin
               // diagonal magnitude 3 up to 9, off-diagonal entries within -1 to 1
               if (i == j) begin
                  mag_int = $urandom_range(3, 8) * 65536 + $urandom_range(0, 65535);
                  mat[i][j] = $urandom_range(0, 1) ? -$signed(mag_int) : $signed(mag_int);
               end else begin
                  mat[i][j] = $signed($urandom_range(0, 131072)) - 32'sd65536;
               end
            end else if (kind < 75) begin
               mat[i][j] = $urandom;
            end else if (kind < 88) begin
               // duplicated first row makes it singular from order two up
               mat[i][j] = (i == 1) ? mat[0][j] :
                           $signed($urandom_range(0, 8)) * mig_pkg::Q_ONE
                           - 32'sd4 * mig_pkg::Q_ONE;
            end else begin
               mat[i][j] = ($signed($urandom_range(0, 8)) - 32'sd4) * mig_pkg::Q_ONE;
            end
         end
      for (i = 0; i < n; i++)
         for (j = 0; j < n; j++) send_element(mat[i][j]);
   endtask

   task automatic test_random_matrices();
      int unsigned pick, size_val, thresh, n, reps;
      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4 && big_matrices < 2) begin
            size_val = big_matrices == 0 ? 15 : 8;
            big_matrices++;
         end else if (pick < 20) begin
            size_val = $urandom_range(5, 6);
         end else begin
            size_val = $urandom_range(1, 4);
         end
         case ($urandom_range(0, 3))
            0: thresh = 0;
            1: thresh = 16'hffff;
            2: thresh = $urandom_range(0, 65535);
            default: thresh = $urandom_range(0, 64);
         endcase
         configure(size_val, thresh);
         n = (size_val > mig_pkg::MAX_ORDER) ? mig_pkg::MAX_ORDER : size_val;
         reps = (n >= 7) ? 1 : $urandom_range(1, 3);
         repeat (reps) send_random_matrix(n);
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.element <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= '0;
      csr_bus.data <= '0;
      error_count = 0;
      burst_left = 0;
      items_sent = 0;
      big_matrices = 0;
      loaded_count = 0;
      size_reg = 4'd8;
      threshold_reg = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_order_one_extremes();
      test_size_clamping();
      test_threshold_edge();
      test_pivot_swap_and_singular();
      test_partial_load_dropped();
      test_random_matrices();
      wait_idle();
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/mig_pkg.sv
rtl/core/mig_ifc.sv
rtl/core/mig_ram.sv
rtl/core/mig_div.sv
rtl/core/matrix_inverse_gauss_jordan.sv
test/tb_matrix_inverse_gauss_jordan.sv
